@@ rtl/lbps_pkg.sv @@
`default_nettype none

package lbps_pkg;

  localparam int LED_COUNT    = 64;
  localparam int SLOT_W       = 6;
  localparam int COLOR_W      = 24;
  localparam int FRAME_W      = 16;
  localparam int DUTY_W       = 16;
  localparam int BIT_CNT_W    = 5;
  localparam int LAST_BIT_POS = COLOR_W - 1;
  localparam int REG_IDX_W    = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ONE_DUTY  = 1'b0,
    REG_ZERO_DUTY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               lit;
    logic [FRAME_W-1:0] on_cnt;
    logic [FRAME_W-1:0] off_cnt;
  } led_state_t;

  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/lbps_ifs.sv @@
`default_nettype none

interface lbps_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [lbps_pkg::SLOT_W-1:0]  led_slot;
  logic [lbps_pkg::COLOR_W-1:0] color_grb;
  logic [lbps_pkg::FRAME_W-1:0] on_frames;
  logic [lbps_pkg::FRAME_W-1:0] off_frames;

  modport source (output valid, led_slot, color_grb, on_frames, off_frames, input ready);
  modport sink (input valid, led_slot, color_grb, on_frames, off_frames, output ready);
endinterface

interface lbps_duty_if;
  logic                        valid;
  logic                        ready;
  logic [lbps_pkg::DUTY_W-1:0] duty;
  logic                        last_bit;

  modport source (output valid, duty, last_bit, input ready);
  modport sink (input valid, duty, last_bit, output ready);
endinterface

`default_nettype wire

@@ rtl/lbps_blink.sv @@
`default_nettype none

module lbps_blink (
  input  wire logic             clk,
  input  wire logic             rst,
  lbps_pixel_if.sink            pixel,
  output lbps_pkg::frame_t      frame,
  input  wire logic             take
);

  logic                              s1_valid;
  logic [lbps_pkg::SLOT_W-1:0]       s1_slot;
  logic [lbps_pkg::COLOR_W-1:0]      s1_color;
  logic [lbps_pkg::FRAME_W-1:0]      s1_on;
  logic [lbps_pkg::FRAME_W-1:0]      s1_off;

  lbps_pkg::led_state_t              state_mem [lbps_pkg::LED_COUNT];
  logic [lbps_pkg::LED_COUNT-1:0]    vld;
  lbps_pkg::led_state_t              mem_q;
  logic                              vld_q;
  logic                              byp_use;
  lbps_pkg::led_state_t              byp_entry;

  lbps_pkg::led_state_t              cur;
  lbps_pkg::led_state_t              state_next;
  logic                              blink_en;
  logic [lbps_pkg::COLOR_W-1:0]      color_out;
  logic                              accept;
  logic                              wr;

  assign accept      = pixel.valid && pixel.ready;
  assign pixel.ready = !s1_valid || take;
  assign blink_en    = (s1_on != '0) && (s1_off != '0);
  assign wr          = take && blink_en;

  always_comb begin
    if (byp_use) begin
      cur = byp_entry;
    end else if (vld_q) begin
      cur = mem_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    state_next = cur;
    color_out  = s1_color;
    if (blink_en) begin
      if (cur.lit) begin
        if (cur.on_cnt < s1_on) begin
          state_next.on_cnt = cur.on_cnt + lbps_pkg::FRAME_W'(1);
        end else begin
          state_next.lit    = 1'b0;
          state_next.on_cnt = '0;
        end
      end else begin
        color_out = '0;
        if (cur.off_cnt < s1_off) begin
          state_next.off_cnt = cur.off_cnt + lbps_pkg::FRAME_W'(1);
        end else begin
          state_next.lit     = 1'b1;
          state_next.off_cnt = '0;
        end
      end
    end
  end

  assign frame.valid = s1_valid;
  assign frame.color = color_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      vld      <= '0;
      byp_use  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        byp_use  <= wr && (pixel.led_slot == s1_slot);
      end else if (take) begin
        s1_valid <= 1'b0;
      end
      if (wr) begin
        vld[s1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot   <= pixel.led_slot;
      s1_color  <= pixel.color_grb;
      s1_on     <= pixel.on_frames;
      s1_off    <= pixel.off_frames;
      mem_q     <= state_mem[pixel.led_slot];
      vld_q     <= vld[pixel.led_slot];
      byp_entry <= state_next;
    end
    if (wr) begin
      state_mem[s1_slot] <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> s1_valid)
    else $error("frame taken from an empty stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !take |=> s1_valid && $stable(s1_slot) && $stable(s1_color))
    else $error("stalled frame changed");

  a_dark_is_black: assert property (@(posedge clk) disable iff (rst)
    s1_valid && blink_en && !cur.lit |-> color_out == '0)
    else $error("dark LED emitted color");
`endif

endmodule

`default_nettype wire

@@ rtl/lbps_serializer.sv @@
`default_nettype none

module lbps_serializer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lbps_pkg::frame_t              frame,
  output logic                               take,
  input  wire logic [lbps_pkg::DUTY_W-1:0]   one_duty,
  input  wire logic [lbps_pkg::DUTY_W-1:0]   zero_duty,
  lbps_duty_if.source                        word
);

  logic                              busy;
  logic [lbps_pkg::COLOR_W-1:0]      shift;
  logic [lbps_pkg::BIT_CNT_W-1:0]    cnt;
  logic                              is_last;
  logic                              xfer;
  logic                              free;

  assign is_last       = cnt == lbps_pkg::BIT_CNT_W'(lbps_pkg::LAST_BIT_POS);
  assign xfer          = word.valid && word.ready;
  assign free          = !busy || (xfer && is_last);
  assign take          = frame.valid && free;

  assign word.valid    = busy;
  assign word.duty     = shift[lbps_pkg::COLOR_W-1] ? one_duty : zero_duty;
  assign word.last_bit = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (xfer) begin
      if (is_last) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + lbps_pkg::BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      shift <= frame.color;
    end else if (xfer) begin
      shift <= {shift[lbps_pkg::COLOR_W-2:0], 1'b0};
    end
  end

`ifndef ASSERT_OFF
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    take |=> busy && cnt == '0)
    else $error("load did not restart the bit count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !word.ready |=> $stable(shift) && $stable(cnt))
    else $error("stalled word changed");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0)
    else $error("bit count left over while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/led_blink_pixel_serializer_unit.sv @@
`default_nettype none

// channel  | dir | payload                                      | transfer
// pixel    | in  | led_slot, color_grb, on_frames, off_frames   | valid & ready
// word     | out | duty, last_bit                               | valid & ready
// wr_*     | in  | wr_index, wr_data                            | wr_en
//
// Each pixel yields 24 words, bit 23 first, one per cycle while word.ready is high.
// In the blink stage a pixel's state is read, updated and written back; the pixel is taken
// when the shifter is idle or at the transfer of the previous pixel's last word.
// Reset clears all blink state (per-LED valid bits) and loads the duty defaults.
// Output stalls hold the shifter; the blink stage then holds, then pixel.ready drops.

module led_blink_pixel_serializer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [lbps_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic [lbps_pkg::DUTY_W-1:0]     wr_data,
  lbps_pixel_if.sink                           pixel,
  lbps_duty_if.source                          word
);

  logic [lbps_pkg::DUTY_W-1:0] one_duty;
  logic [lbps_pkg::DUTY_W-1:0] zero_duty;
  lbps_pkg::frame_t            frame;
  logic                        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_duty  <= lbps_pkg::DUTY_W'(60);
      zero_duty <= lbps_pkg::DUTY_W'(30);
    end else if (wr_en) begin
      case (lbps_pkg::reg_idx_t'(wr_index))
        lbps_pkg::REG_ONE_DUTY:  one_duty  <= wr_data;
        lbps_pkg::REG_ZERO_DUTY: zero_duty <= wr_data;
        default: ;
      endcase
    end
  end

  lbps_blink u_blink (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .frame (frame),
    .take  (take)
  );

  lbps_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .take      (take),
    .one_duty  (one_duty),
    .zero_duty (zero_duty),
    .word      (word)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 70;
  localparam int WORDS_PER_PIXEL = lbps_pkg::COLOR_W;

  typedef struct packed {
    logic [lbps_pkg::SLOT_W-1:0]  slot;
    logic [lbps_pkg::COLOR_W-1:0] color;
    logic [lbps_pkg::FRAME_W-1:0] on_frames;
    logic [lbps_pkg::FRAME_W-1:0] off_frames;
  } pixel_t;

  typedef struct packed {
    logic [lbps_pkg::DUTY_W-1:0] duty;
    logic                        last_bit;
  } duty_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           wr_en;
  logic [lbps_pkg::REG_IDX_W-1:0] wr_index;
  logic [lbps_pkg::DUTY_W-1:0]    wr_data;

  lbps_pixel_if pix ();
  lbps_duty_if  word_ch ();

  led_blink_pixel_serializer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixel    (pix),
    .word     (word_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block: duty registers and per-LED blink state
  logic [lbps_pkg::DUTY_W-1:0]  one_duty_q;
  logic [lbps_pkg::DUTY_W-1:0]  zero_duty_q;
  logic                         led_lit [lbps_pkg::LED_COUNT];
  logic [lbps_pkg::FRAME_W-1:0] led_on_cnt [lbps_pkg::LED_COUNT];
  logic [lbps_pkg::FRAME_W-1:0] led_off_cnt [lbps_pkg::LED_COUNT];

  pixel_t     pending_pixels [$];
  duty_word_t expected_words [$];
  pixel_t     cur_pixel;
  duty_word_t got_word;
  duty_word_t want_word;
  int         mismatches;
  int         idle_cycles;
  int         burst_left;
  int         gap_left;
  int         gap_max;
  logic [15:0] stall_mask;
  logic [3:0]  stall_tick;
  logic [lbps_pkg::SLOT_W-1:0] slot_pool [4];

  function automatic logic [lbps_pkg::COLOR_W-1:0] blink_color(pixel_t p);
    int s;
    s = int'(p.slot);
    if (s >= lbps_pkg::LED_COUNT || p.on_frames == '0 || p.off_frames == '0) return p.color;
    if (led_lit[s]) begin
      if (led_on_cnt[s] < p.on_frames) begin
        led_on_cnt[s] = led_on_cnt[s] + 1'b1;
      end else begin
        led_lit[s] = 1'b0;
        led_on_cnt[s] = '0;
      end
      return p.color;
    end
    if (led_off_cnt[s] < p.off_frames) begin
      led_off_cnt[s] = led_off_cnt[s] + 1'b1;
    end else begin
      led_lit[s] = 1'b1;
      led_off_cnt[s] = '0;
    end
    return '0;
  endfunction

  function automatic void predict_words(pixel_t p);
    logic [lbps_pkg::COLOR_W-1:0] shown;
    duty_word_t w;
    shown = blink_color(p);
    for (int b = lbps_pkg::COLOR_W - 1; b >= 0; b--) begin
      w.duty = shown[b] ? one_duty_q : zero_duty_q;
      w.last_bit = (b == 0);
      expected_words.push_back(w);
    end
  endfunction

  function automatic pixel_t make_pixel(logic [lbps_pkg::SLOT_W-1:0] slot,
                                        logic [lbps_pkg::COLOR_W-1:0] color,
                                        logic [lbps_pkg::FRAME_W-1:0] on_f,
                                        logic [lbps_pkg::FRAME_W-1:0] off_f);
    pixel_t p;
    p.slot = slot;
    p.color = color;
    p.on_frames = on_f;
    p.off_frames = off_f;
    return p;
  endfunction

  // mostly blink sequences on a few LEDs, some wide-open noise and disabled frames
  function automatic pixel_t random_pixel();
    int pick;
    pixel_t p;
    pick = $urandom_range(0, 99);
    p.color = lbps_pkg::COLOR_W'($urandom());
    if (pick < 70) begin
      p.slot = slot_pool[$urandom_range(0, 3)];
      p.on_frames = lbps_pkg::FRAME_W'($urandom_range(1, 4));
      p.off_frames = lbps_pkg::FRAME_W'($urandom_range(1, 4));
    end else if (pick < 85) begin
      p.slot = lbps_pkg::SLOT_W'($urandom());
      p.on_frames = lbps_pkg::FRAME_W'($urandom());
      p.off_frames = lbps_pkg::FRAME_W'($urandom());
    end else begin
      p.slot = ($urandom_range(0, 1) != 0) ? slot_pool[$urandom_range(0, 3)]
                                           : lbps_pkg::SLOT_W'($urandom());
      p.on_frames = ($urandom_range(0, 1) != 0) ? '0 : lbps_pkg::FRAME_W'($urandom());
      p.off_frames = (p.on_frames != '0) ? '0 : lbps_pkg::FRAME_W'($urandom_range(0, 3));
    end
    return p;
  endfunction

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || expected_words.size() != 0 || pix.valid)
      @(posedge clk);
  endtask

  task automatic write_duties(logic [lbps_pkg::DUTY_W-1:0] one_v,
                              logic [lbps_pkg::DUTY_W-1:0] zero_v);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= lbps_pkg::REG_ONE_DUTY;
    wr_data <= one_v;
    @(posedge clk);
    wr_index <= lbps_pkg::REG_ZERO_DUTY;
    wr_data <= zero_v;
    @(posedge clk);
    wr_en <= 1'b0;
    one_duty_q = one_v;
    zero_duty_q = zero_v;
  endtask

  task automatic run_random_phase(logic [lbps_pkg::DUTY_W-1:0] one_v,
                                  logic [lbps_pkg::DUTY_W-1:0] zero_v,
                                  int gaps, logic [15:0] mask);
    wait_idle();
    write_duties(one_v, zero_v);
    gap_max = gaps;
    stall_mask = mask;
    for (int i = 0; i < 4; i++) slot_pool[i] = lbps_pkg::SLOT_W'($urandom());
    for (int i = 0; i < PHASE_ITEMS; i++) pending_pixels.push_back(random_pixel());
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (pix.valid && pix.ready) predict_words(cur_pixel);
      if (pix.valid && !pix.ready) begin
        // hold
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        pix.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        cur_pixel = pending_pixels.pop_front();
        pix.valid <= 1'b1;
        pix.led_slot <= cur_pixel.slot;
        pix.color_grb <= cur_pixel.color;
        pix.on_frames <= cur_pixel.on_frames;
        pix.off_frames <= cur_pixel.off_frames;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // receiver: stall on a rotating mask
  always @(posedge clk) begin
    if (rst) begin
      word_ch.ready <= 1'b0;
      stall_tick <= '0;
    end else begin
      word_ch.ready <= stall_mask[stall_tick];
      stall_tick <= stall_tick + 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && word_ch.valid && word_ch.ready) begin
      got_word.duty = word_ch.duty;
      got_word.last_bit = word_ch.last_bit;
      if (expected_words.size() == 0) begin
        $error("unexpected transfer: duty=%0d last_bit=%0b", got_word.duty, got_word.last_bit);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.duty !== want_word.duty) begin
          $error("duty: expected %0d, actual %0d", want_word.duty, got_word.duty);
          mismatches++;
        end
        if (got_word.last_bit !== want_word.last_bit) begin
          $error("last_bit: expected %0b, actual %0b", want_word.last_bit, got_word.last_bit);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (word_ch.valid && word_ch.ready) || wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wr_en = 1'b0;
    wr_index = lbps_pkg::REG_ONE_DUTY;
    wr_data = '0;
    pix.valid = 1'b0;
    pix.led_slot = '0;
    pix.color_grb = '0;
    pix.on_frames = '0;
    pix.off_frames = '0;
    word_ch.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    one_duty_q = 16'd60;
    zero_duty_q = 16'd30;
    for (int i = 0; i < lbps_pkg::LED_COUNT; i++) begin
      led_lit[i] = 1'b0;
      led_on_cnt[i] = '0;
      led_off_cnt[i] = '0;
    end
    gap_max = 3;
    stall_mask = 16'b1011_0111_1110_1101;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // field extremes, blinking disabled by either count
    pending_pixels.push_back(make_pixel(6'd0, 24'h000000, 16'd0, 16'd0));
    pending_pixels.push_back(make_pixel(6'd63, 24'hFFFFFF, 16'd0, 16'd0));
    pending_pixels.push_back(make_pixel(6'd1, 24'hAAAAAA, 16'hFFFF, 16'd0));
    pending_pixels.push_back(make_pixel(6'd2, 24'h555555, 16'd0, 16'hFFFF));
    pending_pixels.push_back(make_pixel(6'd3, 24'h800001, 16'd1, 16'd0));
    // full blink cycle: dark phase end still zero, lit phase end still colored
    for (int i = 0; i < 7; i++)
      pending_pixels.push_back(make_pixel(6'd5,
                                          lbps_pkg::COLOR_W'($urandom()) | 24'h010101,
                                          16'd2, 16'd1));
    // on counter left above a lowered limit
    for (int i = 0; i < 5; i++)
      pending_pixels.push_back(make_pixel(6'd6, 24'hC3C3C3, 16'd5, 16'd1));
    pending_pixels.push_back(make_pixel(6'd6, 24'h3C3C3C, 16'd1, 16'd1));
    pending_pixels.push_back(make_pixel(6'd63, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
    pending_pixels.push_back(make_pixel(6'd63, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
    // disabled frame leaves blink state untouched
    pending_pixels.push_back(make_pixel(6'd5, 24'h123456, 16'd0, 16'd3));
    pending_pixels.push_back(make_pixel(6'd5, 24'h654321, 16'd2, 16'd1));
    pending_pixels.push_back(make_pixel(6'd5, 24'h654321, 16'd2, 16'd1));

    run_random_phase(16'hFFFF, 16'h0000, 0, 16'hFFFF);
    run_random_phase(16'h0000, 16'hFFFF, 6, 16'hFFFF);
    run_random_phase(lbps_pkg::DUTY_W'($urandom()), lbps_pkg::DUTY_W'($urandom()), 4,
                     16'($urandom()) | 16'h0101);
    run_random_phase(16'h0001, 16'hFFFE, 0, 16'b1000_1000_0100_0010);
    run_random_phase(lbps_pkg::DUTY_W'($urandom()), lbps_pkg::DUTY_W'($urandom()), 10,
                     16'($urandom()) | 16'h1010);

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lbps_pkg.sv
rtl/lbps_ifs.sv
rtl/lbps_blink.sv
rtl/lbps_serializer.sv
rtl/led_blink_pixel_serializer_unit.sv
tb/sv/tb_top.sv
